// File: design/psdwc_pkg.sv
// ----------------------------------------------------------------------------
// psdwc_pkg
// Shared constants and types of the PLL divider word calculator.
// ----------------------------------------------------------------------------
package psdwc_pkg;

   localparam int unsigned FREQ_W = 32;
   localparam int unsigned REF_W  = 27;
   localparam int unsigned EXP_W  = 3;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned MAX_EXP = 5;

   localparam logic [REF_W-1:0] REF_RESET = 27'd26000000;
   localparam logic [FREQ_W-1:0] MIN_LO_HZ = 32'd85000000;
   localparam logic [FREQ_W-1:0] MAX_LO_HZ = 32'd4200000000;
   localparam logic [37:0] TOP_VCO_HZ = 38'd5400000000;
   localparam logic [32:0] FBK_SWITCH_HZ = 33'd3200000000;

   localparam logic [1:0] FBK_CODE_TWO  = 2'b01;
   localparam logic [1:0] FBK_CODE_FOUR = 2'b10;

   typedef struct packed {
      logic             in_range;
      logic [EXP_W-1:0] lo_div_exp;
      logic             fbk_is_four;
   } meta_type;

endpackage

// File: design/psdwc_prep.sv
// ----------------------------------------------------------------------------
// psdwc_prep
// Range check, LO divider choice and scaling of the VCO frequency.
// ----------------------------------------------------------------------------
module psdwc_prep #(
   parameter int unsigned FRAC_BITS = 24,
   parameter int unsigned SW = 32 + FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [psdwc_pkg::FREQ_W-1:0] in_freq,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [SW-1:0]                out_work,
   output psdwc_pkg::meta_type          out_meta
);
   import psdwc_pkg::*;

   logic              valid_ff, valid_in;
   logic [SW-1:0]     work_ff, work_in;
   meta_type          meta_ff, meta_in;
   logic              ok;
   logic [EXP_W-1:0]  power;
   logic [32:0]       fvco;
   logic              fbk4;
   logic [SW:0]       wide;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      ok = (in_freq >= MIN_LO_HZ) && (in_freq <= MAX_LO_HZ);
      power = '0;
      // Largest power of two whose multiple of the request stays within 5.4 GHz.
      for (int p = 1; p <= MAX_EXP; p++) begin
         if ((38'(in_freq) << p) <= TOP_VCO_HZ) begin
            power = EXP_W'(p);
         end
      end
      fvco = 33'(in_freq) << power;
      fbk4 = (fvco >= FBK_SWITCH_HZ);
      wide = ((SW+1)'(fvco) << FRAC_BITS) >> (fbk4 ? 2 : 1);
      if (ok) begin
         work_in = wide[SW-1:0];
         meta_in.in_range = 1'b1;
         meta_in.lo_div_exp = power;
         meta_in.fbk_is_four = fbk4;
      end else begin
         work_in = '0;
         meta_in = '0;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         work_ff <= work_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
   assign out_meta  = meta_ff;

endmodule

// File: design/psdwc_cell.sv
// ----------------------------------------------------------------------------
// psdwc_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module psdwc_cell #(
   parameter int unsigned SW = 56
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [psdwc_pkg::REF_W-1:0] ref_clock,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [psdwc_pkg::REF_W-1:0] in_rem,
   input  logic [SW-1:0]               in_work,
   input  psdwc_pkg::meta_type         in_meta,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [psdwc_pkg::REF_W-1:0] out_rem,
   output logic [SW-1:0]               out_work,
   output psdwc_pkg::meta_type         out_meta
);
   import psdwc_pkg::*;

   logic             valid_ff, valid_in;
   logic [REF_W-1:0] rem_ff, rem_in;
   logic [SW-1:0]    work_ff, work_in;
   meta_type         meta_ff;
   logic [REF_W:0]   rem_sh;
   logic [REF_W+1:0] diff;
   logic             take;

   assign in_ready = !valid_ff || out_ready;

   // The work word shifts dividend bits out at the top and quotient bits in
   // at the bottom, so after the last cell it holds the whole quotient.
   always_comb begin
      rem_sh  = {in_rem, in_work[SW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, ref_clock};
      take    = !diff[REF_W+1];
      rem_in  = take ? diff[REF_W-1:0] : rem_sh[REF_W-1:0];
      work_in = {in_work[SW-2:0], take};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;
   assign out_meta  = meta_ff;

endmodule

// File: design/psdwc_pack.sv
// ----------------------------------------------------------------------------
// psdwc_pack
// Output register: packs the divider N into the three register words.
// ----------------------------------------------------------------------------
module psdwc_pack #(
   parameter int unsigned FRAC_BITS = 24,
   parameter int unsigned SW = 32 + FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [SW-1:0]                in_ndiv,
   input  psdwc_pkg::meta_type          in_meta,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_in_range,
   output logic [psdwc_pkg::EXP_W-1:0]  rsp_lo_div_exp,
   output logic                         rsp_fbk_is_four,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_one,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_two,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_three
);
   import psdwc_pkg::*;

   logic              valid_ff, valid_in;
   meta_type          meta_ff, meta_in;
   logic [WORD_W-1:0] one_ff, one_in;
   logic [WORD_W-1:0] two_ff, two_in;
   logic [WORD_W-1:0] three_ff, three_in;
   logic [23:0]       frac24;
   logic [8:0]        int_low;

   assign in_ready = !valid_ff || !rsp_stall;

   always_comb begin
      int_low = in_ndiv[FRAC_BITS +: 9];
      frac24  = 24'(in_ndiv[FRAC_BITS-1:0]) << (24 - FRAC_BITS);
      meta_in = in_meta;
      if (in_meta.in_range) begin
         one_in = {int_low, in_meta.lo_div_exp,
                   in_meta.fbk_is_four ? FBK_CODE_FOUR : FBK_CODE_TWO, 2'b00};
         two_in   = frac24[23:8];
         three_in = {frac24[7:0], 8'h00};
      end else begin
         meta_in  = '0;
         one_in   = '0;
         two_in   = '0;
         three_in = '0;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         meta_ff  <= meta_in;
         one_ff   <= one_in;
         two_ff   <= two_in;
         three_ff <= three_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_in_range    = meta_ff.in_range;
   assign rsp_lo_div_exp  = meta_ff.lo_div_exp;
   assign rsp_fbk_is_four = meta_ff.fbk_is_four;
   assign rsp_word_one    = one_ff;
   assign rsp_word_two    = two_ff;
   assign rsp_word_three  = three_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |->
         rsp_word_one == '0 && rsp_word_two == '0 && rsp_word_three == '0 &&
         rsp_lo_div_exp == '0 && !rsp_fbk_is_four)
      else $error("rejected item carries nonzero fields");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |-> rsp_lo_div_exp <= EXP_W'(MAX_EXP))
      else $error("LO divider exponent out of range");

   a_word_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |->
         rsp_word_one[6:4] == rsp_lo_div_exp &&
         rsp_word_one[3:2] == (rsp_fbk_is_four ? FBK_CODE_FOUR : FBK_CODE_TWO) &&
         rsp_word_one[1:0] == 2'b00 && rsp_word_three[7:0] == 8'h00)
      else $error("word one fields disagree with the item");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(one_ff))
      else $error("stalled result changed");

endmodule

// File: design/pll_synth_divider_word_calc_unit.sv
// ----------------------------------------------------------------------------
// pll_synth_divider_word_calc_unit
// Fractional-N PLL divider word calculator, top level.
// ----------------------------------------------------------------------------
// A new item can be accepted in every cycle unless req_stall is high. Each item
// passes the register for the range check and VCO scaling, then the FRAC_BITS
// + 32 cells of the divider row, which produce one quotient bit of N each, and
// then the output register that packs the words. The reference clock register
// is read by every cell, so write it only while no item is in flight.
module pll_synth_divider_word_calc_unit #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [psdwc_pkg::REF_W-1:0]  csr_ref_clock_hz,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [psdwc_pkg::FREQ_W-1:0] req_lo_freq_hz,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_in_range,
   output logic [psdwc_pkg::EXP_W-1:0]  rsp_lo_div_exp,
   output logic                         rsp_fbk_is_four,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_one,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_two,
   output logic [psdwc_pkg::WORD_W-1:0] rsp_word_three
);
   import psdwc_pkg::*;

   localparam int unsigned SW = 32 + FRAC_BITS;

   logic [REF_W-1:0] ref_ff, ref_in;
   logic             prep_ready;

   logic [SW:0]      st_valid;
   logic [SW:0]      st_ready;
   logic [REF_W-1:0] st_rem  [SW+1];
   logic [SW-1:0]    st_work [SW+1];
   meta_type         st_meta [SW+1];

   assign csr_ready = 1'b1;
   assign ref_in = (csr_valid && csr_ready) ? csr_ref_clock_hz : ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else begin
         ref_ff <= ref_in;
      end
   end

   assign req_stall = !prep_ready;
   assign st_rem[0] = '0;

   psdwc_prep #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .in_freq   (req_lo_freq_hz),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .out_work  (st_work[0]),
      .out_meta  (st_meta[0])
   );

   for (genvar i = 0; i < SW; i++) begin : g_cell
      psdwc_cell #(.SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ref_clock (ref_ff),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_rem    (st_rem[i]),
         .in_work   (st_work[i]),
         .in_meta   (st_meta[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_rem   (st_rem[i+1]),
         .out_work  (st_work[i+1]),
         .out_meta  (st_meta[i+1])
      );
   end

   psdwc_pack #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (st_valid[SW]),
      .in_ready        (st_ready[SW]),
      .in_ndiv         (st_work[SW]),
      .in_meta         (st_meta[SW]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_in_range    (rsp_in_range),
      .rsp_lo_div_exp  (rsp_lo_div_exp),
      .rsp_fbk_is_four (rsp_fbk_is_four),
      .rsp_word_one    (rsp_word_one),
      .rsp_word_two    (rsp_word_two),
      .rsp_word_three  (rsp_word_three)
   );

   // The final remainder is not needed by the packer.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      st_valid[SW] && ref_ff != '0 |-> st_rem[SW] < ref_ff)
      else $error("divider remainder not below the reference clock");

   a_ref_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !st_valid[SW] && !rsp_valid)
      else $error("reference clock written with an item in flight");

   a_stall_ripple: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && st_valid[SW] |-> !st_ready[SW])
      else $error("last cell overran a stalled output");

endmodule
